// ===== hdl/pinhole_camera_ray_direction_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pinhole camera ray direction core
// Each macro places one concurrent assertion clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_CAMERA_RAY_DIRECTION_CORE_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_DIRECTION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCRD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrd_pkg
// Types and fixed constants of the pinhole camera ray direction core.
// ----------------------------------------------------------------------------
package pcrd_pkg;

	// Configuration port.
	localparam int REG_W     = 63;
	localparam int REG_IDX_W = 3;
	localparam int SIZE_W    = 13;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_EYE_POSITION    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VIEWPORT_CORNER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VIEWPORT_SPAN_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VIEWPORT_SPAN_Y = 3'd5;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd800;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd600;

	// Fraction bits of the normalized screen coordinates s and t.
	localparam int ST_FRAC = 16;

	// Normalized magnitudes have their leading one at bit NORM_MSB.
	localparam int NORM_MSB = 29;
	localparam int MAGN_W   = NORM_MSB + 1;
	localparam int SQ_W     = 2 * MAGN_W;
	localparam int SSUM_W   = SQ_W + 2;
	localparam int ROOT_W   = SSUM_W + 1;
	localparam int NSQ      = SSUM_W / 2;
	localparam int LEN_W    = NSQ;

	// Output format and final divider.
	localparam int OUT_W    = 16;
	localparam int OUT_FRAC = 14;
	localparam int QO_W     = OUT_FRAC + 1;
	localparam int RQ_W     = LEN_W + OUT_FRAC + 1;
	localparam int OUT_ONE  = 16384;

	typedef logic signed [OUT_W-1:0] dir_t;
	typedef logic [MAGN_W-1:0] nmag_t;

endpackage

// ===== hdl/pinhole_camera_ray_direction_core.sv =====
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle unless m_tready stalls the output; dividers and square root are bit-per-stage.
// Reset: arst_n clears valid bits, skid buffer and registers to defaults.
// ----------------------------------------------------------------------------
`include "pinhole_camera_ray_direction_core_assert.svh"

module pinhole_camera_ray_direction_core
	import pcrd_pkg::*;
#(
	parameter int COORD_INT_BITS  = 12,
	parameter int COORD_FRAC_BITS = 8,
	parameter int COMPONENT_BITS  = 21,
	localparam int CW          = COORD_INT_BITS + COORD_FRAC_BITS,
	localparam int IN_TDATA_W  = ((2 * CW + 7) / 8) * 8,
	localparam int OUT_TDATA_W = 3 * OUT_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [REG_IDX_W-1:0]   wr_addr,
	input  logic [REG_W-1:0]       wr_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // pixel_x, pixel_y, zero fill
	input  logic                   s_tuser,   // mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // dir_x, dir_y, dir_z
);

	localparam int CB   = COMPONENT_BITS;
	localparam int FB   = COORD_FRAC_BITS + 1;
	localparam int NXW  = CW + 1;
	localparam int DVW  = SIZE_W + FB;
	localparam int TMW  = (NXW > DVW) ? NXW : DVW;
	localparam int QW   = COORD_INT_BITS + ST_FRAC;
	localparam int RW   = DVW + QW;
	localparam int SW   = QW + 1;
	localparam int PW   = CB + SW;
	localparam int DSW  = CB + QW + 3;
	localparam int MW   = DSW;
	localparam int NG   = (MW + 7) / 8;
	localparam int GW   = $clog2(NG);
	localparam int MIDW = NORM_MSB + 8;
	localparam int NST  = QW + 58;
	localparam int SU_IDX = QW + 9;

	// Configuration registers.
	logic [SIZE_W-1:0] width_q, height_q;
	logic [REG_W-1:0]  eye_q, corner_q, span_x_q, span_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			eye_q    <= '0;
			corner_q <= '0;
			span_x_q <= '0;
			span_y_q <= '0;
		end else if (wr_en) begin
			unique case (wr_addr)
				REG_IMAGE_WIDTH:     width_q  <= wr_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:    height_q <= wr_data[SIZE_W-1:0];
				REG_EYE_POSITION:    eye_q    <= wr_data;
				REG_VIEWPORT_CORNER: corner_q <= wr_data;
				REG_VIEWPORT_SPAN_X: span_x_q <= wr_data;
				REG_VIEWPORT_SPAN_Y: span_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Pipeline advance and input skid buffer.
	logic [NST-1:0]  vld_sk;
	logic            en, in_acc;
	logic            skid_q, skid_mode_q;
	logic [2*CW-1:0] skid_data_q;

	assign en       = !vld_sk[NST-1] || m_tready;
	assign s_tready = !skid_q;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
			vld_sk <= '0;
		end else if (en) begin
			skid_q <= 1'b0;
			vld_sk <= {vld_sk[NST-2:0], skid_q || in_acc};
		end else if (in_acc) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_acc) begin
			skid_mode_q <= s_tuser;
			skid_data_q <= s_tdata[2*CW-1:0];
		end
	end

	// Stage 1: screen position to division numerators.
	logic            in_mode;
	logic [CW-1:0]   in_px, in_py;
	logic [NXW-1:0]  nx, ny;
	logic [DVW-1:0]  dw, dh;
	logic [TMW-1:0]  t_num;
	logic            t_neg;

	always_comb begin
		in_mode = skid_q ? skid_mode_q : s_tuser;
		in_px   = skid_q ? skid_data_q[CW-1:0] : s_tdata[CW-1:0];
		in_py   = skid_q ? skid_data_q[2*CW-1:CW] : s_tdata[2*CW-1:CW];
		if (in_mode) begin
			nx = {in_px, 1'b0};
			ny = {in_py, 1'b0};
		end else begin
			nx = {in_px[CW-1:COORD_FRAC_BITS], {FB{1'b0}}} | (NXW'(1) << COORD_FRAC_BITS);
			ny = {in_py[CW-1:COORD_FRAC_BITS], {FB{1'b0}}} | (NXW'(1) << COORD_FRAC_BITS);
		end
		dw = {((width_q == '0) ? SIZE_W'(1) : width_q), {FB{1'b0}}};
		dh = {((height_q == '0) ? SIZE_W'(1) : height_q), {FB{1'b0}}};
		t_neg = TMW'(ny) > TMW'(dh);
		t_num = t_neg ? TMW'(ny) - TMW'(dh) : TMW'(dh) - TMW'(ny);
	end

	// Stages 2 to QW+1: restoring dividers for s and t, one quotient bit each.
	logic [RW-1:0] ds_rem_sk [QW+1];
	logic [QW-1:0] ds_quo_sk [QW+1];
	logic [RW-1:0] dt_rem_sk [QW+1];
	logic [QW-1:0] dt_quo_sk [QW+1];
	logic          dt_neg_sk [QW+1];
	logic [RW-1:0] ds_rem_nx [QW];
	logic [QW-1:0] ds_quo_nx [QW];
	logic [RW-1:0] dt_rem_nx [QW];
	logic [QW-1:0] dt_quo_nx [QW];

	always_comb begin
		logic [RW-1:0] dsw, dsh;
		for (int k = 0; k < QW; k++) begin
			dsw = RW'(dw) << (QW - 1 - k);
			dsh = RW'(dh) << (QW - 1 - k);
			ds_rem_nx[k] = ds_rem_sk[k];
			ds_quo_nx[k] = ds_quo_sk[k];
			dt_rem_nx[k] = dt_rem_sk[k];
			dt_quo_nx[k] = dt_quo_sk[k];
			if (ds_rem_sk[k] >= dsw) begin
				ds_rem_nx[k] = ds_rem_sk[k] - dsw;
				ds_quo_nx[k][QW-1-k] = 1'b1;
			end
			if (dt_rem_sk[k] >= dsh) begin
				dt_rem_nx[k] = dt_rem_sk[k] - dsh;
				dt_quo_nx[k][QW-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_rem_sk[0] <= RW'({nx, {ST_FRAC{1'b0}}});
			ds_quo_sk[0] <= '0;
			dt_rem_sk[0] <= RW'({t_num, {ST_FRAC{1'b0}}});
			dt_quo_sk[0] <= '0;
			dt_neg_sk[0] <= t_neg;
			for (int k = 0; k < QW; k++) begin
				ds_rem_sk[k+1] <= ds_rem_nx[k];
				ds_quo_sk[k+1] <= ds_quo_nx[k];
				dt_rem_sk[k+1] <= dt_rem_nx[k];
				dt_quo_sk[k+1] <= dt_quo_nx[k];
				dt_neg_sk[k+1] <= dt_neg_sk[k];
			end
		end
	end

	// Vector components of the configuration.
	logic signed [CB-1:0]   ce [3];
	logic signed [CB-1:0]   cc [3];
	logic signed [CB-1:0]   cx [3];
	logic signed [CB-1:0]   cy [3];
	logic signed [CB:0]     base [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ce[i]   = eye_q[i*CB +: CB];
			cc[i]   = corner_q[i*CB +: CB];
			cx[i]   = span_x_q[i*CB +: CB];
			cy[i]   = span_y_q[i*CB +: CB];
			base[i] = (CB+1)'(cc[i]) - (CB+1)'(ce[i]);
		end
	end

	// Multiply stage: span vectors scaled by s and t.
	logic signed [SW-1:0] s_val, t_val;
	logic signed [PW-1:0] px_sm [3];
	logic signed [PW-1:0] py_sm [3];

	always_comb begin
		s_val = $signed({1'b0, ds_quo_sk[QW]});
		t_val = dt_neg_sk[QW] ? -$signed({1'b0, dt_quo_sk[QW]})
		                      : $signed({1'b0, dt_quo_sk[QW]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				px_sm[i] <= cx[i] * s_val;
				py_sm[i] <= cy[i] * t_val;
			end
		end
	end

	// Sum stage: direction before normalization.
	logic signed [DSW-1:0] d_sa [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_sa[i] <= (DSW'(base[i]) <<< ST_FRAC) + DSW'(px_sm[i]) + DSW'(py_sm[i]);
			end
		end
	end

	// Magnitude stage.
	logic [MW-1:0] mag_sb [3];
	logic [2:0]    neg_sb;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_sb[i] <= d_sa[i][DSW-1];
				mag_sb[i] <= d_sa[i][DSW-1] ? MW'(-d_sa[i]) : MW'(d_sa[i]);
			end
		end
	end

	// Leading one search, first step: per-byte detect on the OR of magnitudes.
	logic [NG*8-1:0] or_pad;
	logic [NG-1:0]   nz_c;
	logic [2:0]      lp_c [NG];
	logic [NG-1:0]   nz_sl1;
	logic [2:0]      lp_sl1 [NG];
	logic [MW-1:0]   mag_sl1 [3];
	logic [2:0]      neg_sl1;

	always_comb begin
		or_pad = (NG*8)'(mag_sb[0] | mag_sb[1] | mag_sb[2]);
		for (int g = 0; g < NG; g++) begin
			nz_c[g] = |or_pad[g*8 +: 8];
			lp_c[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (or_pad[g*8+b]) lp_c[g] = 3'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_sl1  <= nz_c;
			lp_sl1  <= lp_c;
			mag_sl1 <= mag_sb;
			neg_sl1 <= neg_sb;
		end
	end

	// Leading one search, second step: highest nonzero byte.
	logic [GW-1:0] grp_c;
	logic [GW-1:0] grp_sl2;
	logic [2:0]    low_sl2;
	logic          zero_sl2;
	logic [MW-1:0] mag_sl2 [3];
	logic [2:0]    neg_sl2;

	always_comb begin
		grp_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (nz_sl1[g]) grp_c = GW'(g);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_sl2  <= grp_c;
			low_sl2  <= lp_sl1[grp_c];
			zero_sl2 <= ~|nz_sl1;
			mag_sl2  <= mag_sl1;
			neg_sl2  <= neg_sl1;
		end
	end

	// Normalizing shift, coarse then fine: leading one lands at NORM_MSB.
	logic [MW+NORM_MSB-1:0] wide_c [3];
	logic [MIDW-1:0]        mid_sh1 [3];
	logic [2:0]             low_sh1;
	logic                   zero_sh1;
	logic [2:0]             neg_sh1;
	nmag_t                  mag_sh2 [3];
	logic                   zero_sh2;
	logic [2:0]             neg_sh2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_sl2[i], {NORM_MSB{1'b0}}} >> {grp_sl2, 3'b000};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mid_sh1[i] <= wide_c[i][MIDW-1:0];
				mag_sh2[i] <= nmag_t'(mid_sh1[i] >> low_sh1);
			end
			low_sh1  <= low_sl2;
			zero_sh1 <= zero_sl2;
			neg_sh1  <= neg_sl2;
			zero_sh2 <= zero_sh1;
			neg_sh2  <= neg_sh1;
		end
	end

	// Squares of the normalized magnitudes.
	logic [SQ_W-1:0] sq_sq [3];
	nmag_t           mag_sq [3];
	logic            zero_sq;
	logic [2:0]      neg_sq;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_sq[i] <= SQ_W'(mag_sh2[i]) * SQ_W'(mag_sh2[i]);
			end
			mag_sq  <= mag_sh2;
			zero_sq <= zero_sh2;
			neg_sq  <= neg_sh2;
		end
	end

	// Square root, two radicand bits per stage; entry 0 holds the sum of squares.
	logic [ROOT_W-1:0] sr_v_sk   [NSQ+1];
	logic [ROOT_W-1:0] sr_res_sk [NSQ+1];
	nmag_t             sr_mag_sk [NSQ+1][3];
	logic [2:0]        sr_neg_sk [NSQ+1];
	logic              sr_zero_sk [NSQ+1];
	logic [ROOT_W-1:0] sr_v_nx   [NSQ];
	logic [ROOT_W-1:0] sr_res_nx [NSQ];
	logic [SSUM_W-1:0] sq_sum_su;

	assign sq_sum_su = sr_v_sk[0][SSUM_W-1:0];

	always_comb begin
		logic [ROOT_W-1:0] bitv, trial;
		for (int j = 0; j < NSQ; j++) begin
			bitv  = ROOT_W'(1) << (2 * (NSQ - 1 - j));
			trial = sr_res_sk[j] + bitv;
			if (sr_v_sk[j] >= trial) begin
				sr_v_nx[j]   = sr_v_sk[j] - trial;
				sr_res_nx[j] = (sr_res_sk[j] >> 1) + bitv;
			end else begin
				sr_v_nx[j]   = sr_v_sk[j];
				sr_res_nx[j] = sr_res_sk[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_v_sk[0]    <= ROOT_W'(SSUM_W'(sq_sq[0]) + SSUM_W'(sq_sq[1]) + SSUM_W'(sq_sq[2]));
			sr_res_sk[0]  <= '0;
			sr_mag_sk[0]  <= mag_sq;
			sr_neg_sk[0]  <= neg_sq;
			sr_zero_sk[0] <= zero_sq;
			for (int j = 0; j < NSQ; j++) begin
				sr_v_sk[j+1]    <= sr_v_nx[j];
				sr_res_sk[j+1]  <= sr_res_nx[j];
				sr_mag_sk[j+1]  <= sr_mag_sk[j];
				sr_neg_sk[j+1]  <= sr_neg_sk[j];
				sr_zero_sk[j+1] <= sr_zero_sk[j];
			end
		end
	end

	// Output dividers: magnitude * 2^14 / length, rounded to nearest, one bit per stage.
	logic [LEN_W-1:0] len_c;
	logic [RQ_W-1:0]  qd_rem_sk [QO_W+1][3];
	logic [QO_W-1:0]  qd_quo_sk [QO_W+1][3];
	logic [LEN_W-1:0] qd_len_sk [QO_W+1];
	logic [2:0]       qd_neg_sk [QO_W+1];
	logic             qd_zero_sk [QO_W+1];
	logic [RQ_W-1:0]  qd_rem_nx [QO_W][3];
	logic [QO_W-1:0]  qd_quo_nx [QO_W][3];

	assign len_c = sr_res_sk[NSQ][LEN_W-1:0];

	always_comb begin
		logic [RQ_W-1:0] dl;
		for (int k = 0; k < QO_W; k++) begin
			dl = RQ_W'(qd_len_sk[k]) << (QO_W - 1 - k);
			for (int i = 0; i < 3; i++) begin
				qd_rem_nx[k][i] = qd_rem_sk[k][i];
				qd_quo_nx[k][i] = qd_quo_sk[k][i];
				if (qd_rem_sk[k][i] >= dl) begin
					qd_rem_nx[k][i] = qd_rem_sk[k][i] - dl;
					qd_quo_nx[k][i][QO_W-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				qd_rem_sk[0][i] <= RQ_W'({sr_mag_sk[NSQ][i], {OUT_FRAC{1'b0}}})
				                 + RQ_W'(len_c >> 1);
				qd_quo_sk[0][i] <= '0;
			end
			qd_len_sk[0]  <= len_c;
			qd_neg_sk[0]  <= sr_neg_sk[NSQ];
			qd_zero_sk[0] <= sr_zero_sk[NSQ];
			for (int k = 0; k < QO_W; k++) begin
				qd_rem_sk[k+1]  <= qd_rem_nx[k];
				qd_quo_sk[k+1]  <= qd_quo_nx[k];
				qd_len_sk[k+1]  <= qd_len_sk[k];
				qd_neg_sk[k+1]  <= qd_neg_sk[k];
				qd_zero_sk[k+1] <= qd_zero_sk[k];
			end
		end
	end

	// Output register: clamp, sign and the zero-vector case.
	dir_t            dir_so [3];
	logic [QO_W-1:0] qc [3];
	dir_t            dir_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (qd_quo_sk[QO_W][i] > QO_W'(OUT_ONE)) ? QO_W'(OUT_ONE)
			                                            : qd_quo_sk[QO_W][i];
			if (qd_zero_sk[QO_W]) begin
				dir_c[i] = '0;
			end else if (qd_neg_sk[QO_W][i]) begin
				dir_c[i] = -$signed({1'b0, qc[i]});
			end else begin
				dir_c[i] = $signed({1'b0, qc[i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_so <= dir_c;
		end
	end

	assign m_tvalid = vld_sk[NST-1];
	assign m_tdata  = {dir_so[2], dir_so[1], dir_so[0]};

	// A parked request stays parked while the pipeline is stalled.
	`PCRD_ASSERT_NEXT(a_skid_hold, skid_q && !en, skid_q, "skid request lost during stall")

	// Normalization puts the sum of squares at or above 2^58 for nonzero vectors.
	`PCRD_ASSERT_IMPL(a_norm_range, vld_sk[SU_IDX] && !sr_zero_sk[0], sq_sum_su[SSUM_W-1:2*NORM_MSB] != '0, "normalization out of range")

	// Every output component stays within plus or minus one.
	`PCRD_ASSERT_IMPL(a_out_range, m_tvalid, (dir_so[0] <= OUT_ONE) && (dir_so[0] >= -OUT_ONE) && (dir_so[1] <= OUT_ONE) && (dir_so[1] >= -OUT_ONE) && (dir_so[2] <= OUT_ONE) && (dir_so[2] >= -OUT_ONE), "direction component out of range")

endmodule
